[src/bmcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcd_pkg
// Shared constants and types for the multi-click button detector.
// ----------------------------------------------------------------------------
package bmcd_pkg;

  localparam int NUM_BUTTONS   = 3;
  localparam int HISTORY_DEPTH = 6;
  localparam int STAMP_W       = 32;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  // event kinds held in the per-button history
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // history slots checked after the push
  localparam int DOUBLE_BACK = 2;
  localparam int TRIPLE_BACK = 4;

  // register indexes (paddr[2])
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_HOLD   = 1'b1;

  localparam logic [STAMP_W-1:0] WINDOW_RESET = 32'd100;
  localparam logic [STAMP_W-1:0] HOLD_RESET   = 32'd200;

  typedef struct packed {
    logic [STAMP_W-1:0] window;
    logic [STAMP_W-1:0] threshold;
  } bmcd_cfg_t;

  typedef struct packed {
    logic clicked;
    logic released;
    logic double_click;
    logic triple_click;
    logic held;
  } bmcd_lane_res_t;

endpackage

[src/bmcd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcd_in_if / bmcd_out_if
// Valid/ready channels for sample ticks and detector results.
// ----------------------------------------------------------------------------
interface bmcd_in_if import bmcd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] pressed_mask;

  modport source (output valid, output pressed_mask, input ready);
  modport sink   (input valid, input pressed_mask, output ready);
endinterface

interface bmcd_out_if import bmcd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] clicked_mask;
  logic [NUM_BUTTONS-1:0] released_mask;
  logic [NUM_BUTTONS-1:0] double_click_mask;
  logic [NUM_BUTTONS-1:0] triple_click_mask;
  logic [NUM_BUTTONS-1:0] held_mask;

  modport source (output valid, output clicked_mask, output released_mask,
                  output double_click_mask, output triple_click_mask,
                  output held_mask, input ready);
  modport sink   (input valid, input clicked_mask, input released_mask,
                  input double_click_mask, input triple_click_mask,
                  input held_mask, output ready);
endinterface

[src/button_multi_click_detector_core.sv]
`timescale 1ns / 1ps
// Output: a sample beat's result is registered when the beat is accepted and appears in the next cycle.
// Throughput: one sample beat per cycle; the single output register stalls
//   the input only while a result waits and the sink holds ready low.
// Reset (rst, synchronous): clears levels, history kinds and the tick counter,
//   and loads multi_click_window = 100, hold_threshold = 200.
// ----------------------------------------------------------------------------
// button_multi_click_detector_core
// Per-button click, double/triple click and hold detection, one lane a button.
// ----------------------------------------------------------------------------
module button_multi_click_detector_core import bmcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bmcd_in_if.sink           in_ch,
  bmcd_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  bmcd_cfg_t          cfg;
  logic [STAMP_W-1:0] tick_counter;
  logic               accept;
  bmcd_lane_res_t     lane_res [NUM_BUTTONS];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window    <= WINDOW_RESET;
      cfg.threshold <= HOLD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WINDOW: cfg.window    <= pwdata;
        REG_HOLD:   cfg.threshold <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW: prdata = cfg.window;
      REG_HOLD:   prdata = cfg.threshold;
      default:    prdata = '0;
    endcase
  end

  // advance once per accepted sample beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
    end else if (accept) begin
      tick_counter <= tick_counter + 1'b1;
    end
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    bmcd_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .accept (accept),
      .now    (in_ch.pressed_mask[b]),
      .tick   (tick_counter),
      .cfg    (cfg),
      .res    (lane_res[b])
    );
  end

  bmcd_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .lane_res (lane_res),
    .accept   (accept)
  );

endmodule

[src/bmcd_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcd_lane
// Per-button edge detector, event history and click/hold checks.
// ----------------------------------------------------------------------------
module bmcd_lane import bmcd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               now,
  input  logic [STAMP_W-1:0] tick,
  input  bmcd_cfg_t          cfg,
  output bmcd_lane_res_t     res
);

  logic               pressed_before;
  logic [1:0]         kind  [HISTORY_DEPTH];
  logic [STAMP_W-1:0] stamp [HISTORY_DEPTH];

  logic               rise;
  logic               fall;
  logic               push;
  logic [1:0]         kind0;
  logic [STAMP_W-1:0] stamp0;
  logic [1:0]         kind2;
  logic [STAMP_W-1:0] stamp2;
  logic [1:0]         kind4;
  logic [STAMP_W-1:0] stamp4;
  logic [STAMP_W-1:0] age0;
  logic [STAMP_W-1:0] age2;
  logic [STAMP_W-1:0] age4;
  logic               dbl;

  assign rise = now & ~pressed_before;
  assign fall = ~now & pressed_before;
  assign push = rise | fall;

  // history as it stands after this tick's push
  always_comb begin
    if (push) begin
      kind0  = rise ? KIND_PRESS : KIND_RELEASE;
      stamp0 = tick;
      kind2  = kind[DOUBLE_BACK-1];
      stamp2 = stamp[DOUBLE_BACK-1];
      kind4  = kind[TRIPLE_BACK-1];
      stamp4 = stamp[TRIPLE_BACK-1];
    end else begin
      kind0  = kind[0];
      stamp0 = stamp[0];
      kind2  = kind[DOUBLE_BACK];
      stamp2 = stamp[DOUBLE_BACK];
      kind4  = kind[TRIPLE_BACK];
      stamp4 = stamp[TRIPLE_BACK];
    end
  end

  // ages wrap modulo 2^32
  assign age0 = tick - stamp0;
  assign age2 = tick - stamp2;
  assign age4 = tick - stamp4;

  assign dbl = rise && (kind2 == KIND_PRESS) && (age2 <= cfg.window);

  assign res.clicked      = rise;
  assign res.released     = fall;
  assign res.double_click = dbl;
  assign res.triple_click = dbl && (kind4 == KIND_PRESS) && (age4 <= cfg.window);
  assign res.held         = (kind0 == KIND_PRESS) && (age0 >= cfg.threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_before <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        kind[i] <= KIND_NONE;
      end
    end else if (accept) begin
      pressed_before <= now;
      if (push) begin
        kind[0] <= kind0;
        for (int i = 1; i < HISTORY_DEPTH; i++) begin
          kind[i] <= kind[i-1];
        end
      end
    end
  end

  // stamps only matter once their kind slot has been written
  always_ff @(posedge clk) begin
    if (accept && push) begin
      stamp[0] <= tick;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        stamp[i] <= stamp[i-1];
      end
    end
  end

  a_triple_needs_double: assert property (@(posedge clk) disable iff (rst)
    res.triple_click |-> res.double_click)
    else $error("triple click without double click");

  a_double_needs_click: assert property (@(posedge clk) disable iff (rst)
    res.double_click |-> res.clicked)
    else $error("double click without press edge");

  a_level_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> pressed_before == $past(now))
    else $error("previous level not updated on beat");

  a_press_recorded: assert property (@(posedge clk) disable iff (rst)
    (accept && rise) |=> (kind[0] == KIND_PRESS) && (stamp[0] == $past(tick)))
    else $error("press not pushed into history");

endmodule

[src/bmcd_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcd_merge
// Gathers lane results into masks and holds them in the output register.
// ----------------------------------------------------------------------------
module bmcd_merge import bmcd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  bmcd_in_if.sink         in_ch,
  bmcd_out_if.source      out_ch,
  input  bmcd_lane_res_t  lane_res [NUM_BUTTONS],
  output logic            accept
);

  logic                   out_valid;
  logic [NUM_BUTTONS-1:0] clicked_mask;
  logic [NUM_BUTTONS-1:0] released_mask;
  logic [NUM_BUTTONS-1:0] double_click_mask;
  logic [NUM_BUTTONS-1:0] triple_click_mask;
  logic [NUM_BUTTONS-1:0] held_mask;

  // take a new beat whenever the output register is empty or draining
  assign in_ch.ready = ~out_valid | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        clicked_mask[b]      <= lane_res[b].clicked;
        released_mask[b]     <= lane_res[b].released;
        double_click_mask[b] <= lane_res[b].double_click;
        triple_click_mask[b] <= lane_res[b].triple_click;
        held_mask[b]         <= lane_res[b].held;
      end
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.clicked_mask      = clicked_mask;
  assign out_ch.released_mask     = released_mask;
  assign out_ch.double_click_mask = double_click_mask;
  assign out_ch.triple_click_mask = triple_click_mask;
  assign out_ch.held_mask         = held_mask;

endmodule
